FILE: rtl/bbsl_pkg.sv
// Package for the bounded byte stack list unit.
// Operation and status codes, controller states and the control and status words
// shared by the controller and the datapath.
`default_nettype none

package bbsl_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam logic [2:0] MODE_PUSH   = 3'd0;
   localparam logic [2:0] MODE_POP    = 3'd1;
   localparam logic [2:0] MODE_TOP    = 3'd2;
   localparam logic [2:0] MODE_SEARCH = 3'd3;
   localparam logic [2:0] MODE_INSERT = 3'd4;
   localparam logic [2:0] MODE_REMOVE = 3'd5;
   localparam logic [2:0] MODE_READ   = 3'd6;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_EMPTY    = 3'd2;
   localparam logic [2:0] STAT_BADPOS   = 3'd3;
   localparam logic [2:0] STAT_NOTFOUND = 3'd4;

   localparam logic signed [4:0] FIDX_ABSENT = -5'sd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_WAIT,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR
   } state_type;

   typedef enum logic [1:0] {
      TGT_POS,
      TGT_COUNT,
      TGT_LAST
   } tgt_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_COUNT,
      PTR_TGT,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_TGT,
      RD_PTR,
      RD_PTR_DEC,
      RD_PTR_INC
   } rd_sel_type;

   typedef enum logic {
      WR_VALUE,
      WR_RDATA
   } wr_sel_type;

   typedef enum logic {
      DATA_ZERO,
      DATA_RDATA
   } data_sel_type;

   typedef enum logic [1:0] {
      FIDX_ZERO,
      FIDX_NONE,
      FIDX_PTR
   } fidx_sel_type;

   typedef struct packed {
      logic         capture;
      tgt_sel_type  tgt_sel;
      ptr_op_type   ptr_op;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         emit;
      logic [2:0]   status;
      data_sel_type data_sel;
      fidx_sel_type fidx_sel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic ins_bad;
      logic rm_bad;
      logic ptr_at_tgt;
      logic ptr_at_last;
      logic match;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/bounded_byte_stack_list_unit.sv
// Top level of the bounded byte stack list unit: joins the controller and the
// datapath. Uses bbsl_pkg, bbsl_ctrl and bbsl_dpath.
//
// Usage: raise start with req_mode, req_value and req_position; the word is taken
// at a rising edge where start is high and busy is low. Each word gives one result
// word, shown on the rsp_ ports for one cycle while rsp_strobe is high. The
// receiver cannot stall; it must take the result in that cycle.
// With N the count and P the position: errors and the no-op answer from idle without
//   going busy; pop, top, read_at and push shift nothing; insert_at moves the N-P
//   entries from P upward and remove_at moves the N-1-P entries above P; search reads
//   and compares from index 0 up to the first match, or all N entries when absent.
// The entries sit in a single-port memory with a registered read, one read or
// one write a cycle, so each shifted entry takes a read and then a write.
// busy is high from the cycle after accept until the cycle before the strobe;
// a new word can be taken in the strobe cycle.
// Reset empties the store (count zero) and returns the controller to idle;
// entry contents are not cleared.
`default_nettype none

module bounded_byte_stack_list_unit
   import bbsl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [2:0]        req_mode,
   input  wire logic [7:0]        req_value,
   input  wire logic [3:0]        req_position,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_data,
   output logic signed [4:0]      rsp_found_index,
   output logic [4:0]             rsp_count
);

   cmd_type cmd;
   sts_type sts;

   bbsl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   bbsl_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_position    (req_position),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

endmodule

`default_nettype wire

FILE: rtl/bbsl_dpath.sv
// Datapath of the bounded byte stack list unit: entry memory, fill count,
// walk pointer, target position and result word registers. Uses bbsl_pkg.
`default_nettype none

module bbsl_dpath
   import bbsl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        req_value,
   input  wire logic [3:0]        req_position,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_data,
   output logic signed [4:0]      rsp_found_index,
   output logic [4:0]             rsp_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 4) ? CW : 4;

   logic [7:0]        entries_ff [DEPTH];
   logic [7:0]        rdata_ff;
   logic [7:0]        value_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     tgt_ff, tgt_in;
   logic [CW-1:0]     rd_addr;
   logic [7:0]        wdata;
   logic [XW-1:0]     pos_x, cnt_x;
   logic              strobe_ff;
   logic [2:0]        status_ff;
   logic [7:0]        data_ff, data_in;
   logic signed [4:0] fidx_ff, fidx_in;
   logic [4:0]        rcount_ff;

   assign pos_x = XW'(req_position);
   assign cnt_x = XW'(count_ff);

   always_comb begin
      sts.full        = (count_ff == CW'(DEPTH));
      sts.empty       = (count_ff == '0);
      sts.ins_bad     = (pos_x > cnt_x);
      sts.rm_bad      = (pos_x >= cnt_x);
      sts.ptr_at_tgt  = (ptr_ff == tgt_ff);
      sts.ptr_at_last = ((ptr_ff + 1'b1) == count_ff);
      sts.match       = (rdata_ff == value_ff);
   end

   always_comb begin
      case (cmd.tgt_sel)
         TGT_POS:   tgt_in = CW'(pos_x);
         TGT_COUNT: tgt_in = count_ff;
         TGT_LAST:  tgt_in = count_ff - 1'b1;
         default:   tgt_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_ZERO:  ptr_in = '0;
         PTR_COUNT: ptr_in = count_ff;
         PTR_TGT:   ptr_in = tgt_in;
         PTR_INC:   ptr_in = ptr_ff + 1'b1;
         PTR_DEC:   ptr_in = ptr_ff - 1'b1;
         default:   ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_TGT:     rd_addr = tgt_in;
         RD_PTR:     rd_addr = ptr_ff;
         RD_PTR_DEC: rd_addr = ptr_ff - 1'b1;
         RD_PTR_INC: rd_addr = ptr_ff + 1'b1;
         default:    rd_addr = ptr_ff;
      endcase
   end

   assign wdata = (cmd.wr_sel == WR_RDATA) ? rdata_ff : value_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      case (cmd.data_sel)
         DATA_RDATA: data_in = rdata_ff;
         default:    data_in = '0;
      endcase
      case (cmd.fidx_sel)
         FIDX_NONE: fidx_in = FIDX_ABSENT;
         FIDX_PTR:  fidx_in = 5'(ptr_ff);
         default:   fidx_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_ff[ptr_ff[AW-1:0]] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= entries_ff[rd_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_value;
         tgt_ff   <= tgt_in;
      end
      ptr_ff <= ptr_in;
      if (cmd.emit) begin
         status_ff <= cmd.status;
         data_ff   <= data_in;
         fidx_ff   <= fidx_in;
         rcount_ff <= 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_data        = data_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_count       = rcount_ff;

endmodule

`default_nettype wire

FILE: rtl/bbsl_ctrl.sv
// Controller of the bounded byte stack list unit: decodes each request word and
// walks the shift, search and read sequences. Uses bbsl_pkg.
`default_nettype none

module bbsl_ctrl
   import bbsl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [2:0] req_mode,
   input  wire sts_type    sts,
   output logic            busy,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_PUSH:   if (!sts.full) state_in = S_INS_RD;
                  MODE_INSERT: if (!sts.full && !sts.ins_bad) state_in = S_INS_RD;
                  MODE_POP:    if (!sts.empty) state_in = S_REM_RD;
                  MODE_REMOVE: if (!sts.empty && !sts.rm_bad) state_in = S_REM_RD;
                  MODE_TOP:    if (!sts.empty) state_in = S_READ_WAIT;
                  MODE_READ:   if (!sts.empty && !sts.rm_bad) state_in = S_READ_WAIT;
                  MODE_SEARCH: if (!sts.empty) state_in = S_SRCH_RD;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_READ_WAIT: state_in = S_IDLE;
         S_SRCH_RD:   state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (sts.match || sts.ptr_at_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_INS_RD:    state_in = sts.ptr_at_tgt ? S_IDLE : S_INS_WR;
         S_INS_WR:    state_in = S_INS_RD;
         S_REM_RD:    state_in = sts.ptr_at_last ? S_IDLE : S_REM_WR;
         S_REM_WR:    state_in = S_REM_RD;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.tgt_sel  = TGT_COUNT;
      cmd.ptr_op   = PTR_HOLD;
      cmd.rd_sel   = RD_PTR;
      cmd.wr_sel   = WR_VALUE;
      cmd.status   = STAT_OK;
      cmd.data_sel = DATA_ZERO;
      cmd.fidx_sel = FIDX_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_mode)
                  MODE_PUSH: begin
                     if (sts.full) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_FULL;
                     end else begin
                        cmd.tgt_sel = TGT_COUNT;
                        cmd.ptr_op  = PTR_COUNT;
                     end
                  end
                  MODE_INSERT: begin
                     if (sts.full) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_FULL;
                     end else if (sts.ins_bad) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_BADPOS;
                     end else begin
                        cmd.tgt_sel = TGT_POS;
                        cmd.ptr_op  = PTR_COUNT;
                     end
                  end
                  MODE_POP: begin
                     if (sts.empty) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_EMPTY;
                     end else begin
                        cmd.tgt_sel = TGT_LAST;
                        cmd.ptr_op  = PTR_TGT;
                     end
                  end
                  MODE_REMOVE: begin
                     if (sts.empty) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_EMPTY;
                     end else if (sts.rm_bad) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_BADPOS;
                     end else begin
                        cmd.tgt_sel = TGT_POS;
                        cmd.ptr_op  = PTR_TGT;
                     end
                  end
                  MODE_TOP: begin
                     if (sts.empty) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_EMPTY;
                     end else begin
                        cmd.tgt_sel = TGT_LAST;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_TGT;
                     end
                  end
                  MODE_READ: begin
                     if (sts.empty) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_EMPTY;
                     end else if (sts.rm_bad) begin
                        cmd.emit   = 1'b1;
                        cmd.status = STAT_BADPOS;
                     end else begin
                        cmd.tgt_sel = TGT_POS;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_TGT;
                     end
                  end
                  MODE_SEARCH: begin
                     if (sts.empty) begin
                        cmd.emit     = 1'b1;
                        cmd.status   = STAT_NOTFOUND;
                        cmd.fidx_sel = FIDX_NONE;
                     end else begin
                        cmd.ptr_op = PTR_ZERO;
                     end
                  end
                  default: begin
                     cmd.emit = 1'b1;
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            cmd.emit     = 1'b1;
            cmd.data_sel = DATA_RDATA;
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR;
         end
         S_SRCH_CMP: begin
            if (sts.match) begin
               cmd.emit     = 1'b1;
               cmd.fidx_sel = FIDX_PTR;
            end else if (sts.ptr_at_last) begin
               cmd.emit     = 1'b1;
               cmd.status   = STAT_NOTFOUND;
               cmd.fidx_sel = FIDX_NONE;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_INS_RD: begin
            if (sts.ptr_at_tgt) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_VALUE;
               cmd.cnt_inc = 1'b1;
               cmd.emit    = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR_DEC;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_RDATA;
            cmd.ptr_op = PTR_DEC;
         end
         S_REM_RD: begin
            if (sts.ptr_at_last) begin
               cmd.cnt_dec = 1'b1;
               cmd.emit    = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR_INC;
            end
         end
         S_REM_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_RDATA;
            cmd.ptr_op = PTR_INC;
         end
         default: begin
            cmd.emit = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: tb/bbsl_checker.sv
// Checker for the bounded byte stack list unit: watches the request and result
// channels, keeps its own copy of the stack and compares every result word.
// Depends on bbsl_pkg for the operation and status codes.
module bbsl_checker
   import bbsl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [2:0]         req_mode,
   input  wire logic [7:0]         req_value,
   input  wire logic [3:0]         req_position,
   input  wire logic               rsp_strobe,
   input  wire logic [2:0]         rsp_status,
   input  wire logic [7:0]         rsp_data,
   input  wire logic signed [4:0]  rsp_found_index,
   input  wire logic [4:0]         rsp_count,
   output int                      fail_count,
   output int                      outstanding,
   output logic [4:0]              held_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]        status;
      logic [7:0]        data;
      logic signed [4:0] found_index;
      logic [4:0]        count;
   } stack_reply_type;

   logic [7:0]      stack_mem [DEPTH_DEFAULT];
   int              depth_used = 0;
   stack_reply_type awaited_replies [$];

   assign held_count = 5'(depth_used);

   function automatic stack_reply_type apply_stack_op(input logic [2:0] mode,
                                                      input logic [7:0] value,
                                                      input logic [3:0] position);
      stack_reply_type reply;
      int              pos;
      reply = '0;
      reply.status = STAT_OK;
      pos = int'(position);
      case (mode)
         MODE_PUSH: begin
            if (depth_used >= DEPTH_DEFAULT) begin
               reply.status = STAT_FULL;
            end else begin
               stack_mem[depth_used] = value;
               depth_used++;
            end
         end
         MODE_POP: begin
            if (depth_used == 0) reply.status = STAT_EMPTY;
            else depth_used--;
         end
         MODE_TOP: begin
            if (depth_used == 0) reply.status = STAT_EMPTY;
            else reply.data = stack_mem[depth_used - 1];
         end
         MODE_SEARCH: begin
            reply.status = STAT_NOTFOUND;
            reply.found_index = FIDX_ABSENT;
            for (int i = 0; i < depth_used; i++) begin
               if (stack_mem[i] == value && reply.status == STAT_NOTFOUND) begin
                  reply.status = STAT_OK;
                  reply.found_index = 5'(i);
               end
            end
         end
         MODE_INSERT: begin
            if (depth_used >= DEPTH_DEFAULT) begin
               reply.status = STAT_FULL;
            end else if (pos > depth_used) begin
               reply.status = STAT_BADPOS;
            end else begin
               for (int i = depth_used; i > pos; i--) stack_mem[i] = stack_mem[i - 1];
               stack_mem[pos] = value;
               depth_used++;
            end
         end
         MODE_REMOVE: begin
            if (depth_used == 0) begin
               reply.status = STAT_EMPTY;
            end else if (pos >= depth_used) begin
               reply.status = STAT_BADPOS;
            end else begin
               for (int i = pos; i + 1 < depth_used; i++) stack_mem[i] = stack_mem[i + 1];
               depth_used--;
            end
         end
         MODE_READ: begin
            if (depth_used == 0) reply.status = STAT_EMPTY;
            else if (pos >= depth_used) reply.status = STAT_BADPOS;
            else reply.data = stack_mem[pos];
         end
         default: begin
         end
      endcase
      reply.count = 5'(depth_used);
      return reply;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      stack_reply_type want;
      if (reset) begin
         depth_used = 0;
         awaited_replies.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_replies.size() == 0) begin
               flag_mismatch("unexpected word, status", int'(rsp_status), -1);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_data !== want.data)
                  flag_mismatch("data", int'(rsp_data), int'(want.data));
               if (rsp_found_index !== want.found_index)
                  flag_mismatch("found_index", int'(rsp_found_index),
                                int'(want.found_index));
               if (rsp_count !== want.count)
                  flag_mismatch("count", int'(rsp_count), int'(want.count));
            end
         end
         if (start && !busy)
            awaited_replies.push_back(apply_stack_op(req_mode, req_value, req_position));
      end
      outstanding = awaited_replies.size();
   end

endmodule

FILE: tb/bounded_byte_stack_list_unit_tb.sv
// Top of the testbench for the bounded byte stack list unit: clock, reset,
// directed and random command words with sender gaps, and the verdict.
// Depends on bbsl_pkg, the unit itself and bbsl_checker.
module bounded_byte_stack_list_unit_tb
   import bbsl_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MODE_NOP = 3'd7;
   localparam int DRAIN_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_mode = '0;
   logic [7:0]        req_value = '0;
   logic [3:0]        req_position = '0;
   logic              rsp_strobe;
   logic [2:0]        rsp_status;
   logic [7:0]        rsp_data;
   logic signed [4:0] rsp_found_index;
   logic [4:0]        rsp_count;
   int                fail_count;
   int                outstanding;
   logic [4:0]        held_count;
   int                idle_pct = 0;

   always #5ns clock = ~clock;

   bounded_byte_stack_list_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   bbsl_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .held_count      (held_count)
   );

   // entered and left at a falling edge
   task automatic send_word(input logic [2:0] mode, input logic [7:0] value,
                            input logic [3:0] position);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 25) return 8'($urandom_range(3));
      if (r < 35) return 8'hFF;
      if (r < 40) return 8'h00;
      return 8'($urandom);
   endfunction

   task automatic send_random_word(input bit grow);
      int         r;
      int         cnt;
      logic [2:0] mode;
      logic [3:0] position;
      cnt = int'(held_count);
      r = $urandom_range(99);
      if (r < 10) begin
         send_word(3'($urandom_range(7)), 8'($urandom), 4'($urandom_range(15)));
      end else begin
         r = $urandom_range(99);
         if (grow)
            mode = r < 40 ? MODE_PUSH : r < 62 ? MODE_INSERT : r < 72 ? MODE_SEARCH :
                   r < 82 ? MODE_READ : r < 88 ? MODE_TOP : r < 94 ? MODE_REMOVE :
                   MODE_POP;
         else
            mode = r < 10 ? MODE_PUSH : r < 20 ? MODE_INSERT : r < 32 ? MODE_SEARCH :
                   r < 44 ? MODE_READ : r < 50 ? MODE_TOP : r < 75 ? MODE_REMOVE :
                   MODE_POP;
         if ($urandom_range(99) < 15)
            position = 4'($urandom_range(15));
         else if (mode == MODE_INSERT)
            position = 4'($urandom_range(cnt > 15 ? 15 : cnt));
         else if (cnt > 0)
            position = 4'($urandom_range(cnt - 1));
         else
            position = '0;
         send_word(mode, pick_byte(), position);
      end
   endtask

   initial begin
      int phase_idle [3];
      int phase_len [3];
      phase_idle = '{0, 67, 13};
      phase_len  = '{300, 400, 350};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(MODE_TOP,    8'h00, 4'd0);
      send_word(MODE_POP,    8'h00, 4'd0);
      send_word(MODE_READ,   8'h00, 4'd0);
      send_word(MODE_REMOVE, 8'h00, 4'd0);
      send_word(MODE_SEARCH, 8'h00, 4'd0);
      send_word(MODE_INSERT, 8'h11, 4'd1);
      send_word(MODE_INSERT, 8'hFF, 4'd0);
      send_word(MODE_PUSH,   8'h00, 4'd0);
      send_word(MODE_INSERT, 8'h80, 4'd1);
      send_word(MODE_READ,   8'h00, 4'd2);
      send_word(MODE_READ,   8'h00, 4'd3);
      send_word(MODE_READ,   8'h00, 4'd15);
      send_word(MODE_SEARCH, 8'h00, 4'd0);
      send_word(MODE_SEARCH, 8'hFF, 4'd0);
      send_word(MODE_SEARCH, 8'h7F, 4'd0);
      send_word(MODE_TOP,    8'h00, 4'd0);
      send_word(MODE_NOP,    8'hFF, 4'd15);
      send_word(MODE_INSERT, 8'h01, 4'd3);
      send_word(MODE_INSERT, 8'h02, 4'd5);
      send_word(MODE_REMOVE, 8'h00, 4'd4);
      send_word(MODE_REMOVE, 8'h00, 4'd3);
      send_word(MODE_REMOVE, 8'h00, 4'd0);
      send_word(MODE_POP,    8'h00, 4'd0);
      send_word(MODE_POP,    8'h00, 4'd0);
      send_word(MODE_POP,    8'h00, 4'd0);

      for (int p = 0; p < 3; p++) begin
         wait_drained();
         idle_pct = phase_idle[p];
         for (int n = 0; n < phase_len[p]; n++)
            send_random_word(((n / 40) % 2) == 0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: bounded_byte_stack_list_unit.f
rtl/bbsl_pkg.sv
rtl/bbsl_dpath.sv
rtl/bbsl_ctrl.sv
rtl/bounded_byte_stack_list_unit.sv
tb/bbsl_checker.sv
tb/bounded_byte_stack_list_unit_tb.sv
